// ===== rtl/btlv_pkg.sv =====
// Shared types, codes and constants of the BER-TLV stream parser.
package btlv_pkg;

  localparam int DEF_MAX_DEPTH = 8;
  localparam int DEF_POS_WIDTH = 16;

  localparam int TAG_W      = 16;
  localparam int LEN_W      = 16;
  localparam int OFF_W      = 16;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef logic [2:0] role_t;

  localparam role_t ROLE_PAD      = 3'd0;
  localparam role_t ROLE_TAG1     = 3'd1;
  localparam role_t ROLE_TAG2     = 3'd2;
  localparam role_t ROLE_LEN_HEAD = 3'd3;
  localparam role_t ROLE_LEN_EXT  = 3'd4;
  localparam role_t ROLE_VALUE    = 3'd5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SEARCH_TAG    = 4'd0;
  localparam cfg_idx_t REG_SEARCH_NESTED = 4'd1;

  localparam logic [7:0] CONS_MASK     = 8'h20;
  localparam logic [7:0] TAG_MORE_MASK = 8'h1F;
  localparam logic [7:0] LEN_SHORT_MAX = 8'h7F;
  localparam logic [7:0] LEN_LONG1     = 8'h81;
  localparam logic [7:0] LEN_LONG2     = 8'h82;

  typedef struct packed {
    role_t              byte_role;
    logic [TAG_W-1:0]   tag_value;
    logic               is_constructed;
    logic [CNT_W-1:0]   nest_depth;
    logic [LEN_W-1:0]   value_length;
    logic [OFF_W-1:0]   value_offset;
    logic               header_done;
    logic               tag_match;
    logic [CNT_W-1:0]   closed_count;
    logic               format_error;
    logic               nesting_error;
  } result_t;

endpackage

// ===== rtl/btlv_in_if.sv =====
// Input byte channel of the BER-TLV stream parser.
interface btlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

// ===== rtl/btlv_out_if.sv =====
// Result channel of the BER-TLV stream parser, one word per input byte.
interface btlv_out_if;
  logic                          valid;
  logic                          ready;
  btlv_pkg::role_t               byte_role;
  logic [btlv_pkg::TAG_W-1:0]    tag_value;
  logic                          is_constructed;
  logic [btlv_pkg::CNT_W-1:0]    nest_depth;
  logic [btlv_pkg::LEN_W-1:0]    value_length;
  logic [btlv_pkg::OFF_W-1:0]    value_offset;
  logic                          header_done;
  logic                          tag_match;
  logic [btlv_pkg::CNT_W-1:0]    closed_count;
  logic                          format_error;
  logic                          nesting_error;

  modport source (
    output valid, output byte_role, output tag_value, output is_constructed,
    output nest_depth, output value_length, output value_offset, output header_done,
    output tag_match, output closed_count, output format_error, output nesting_error,
    input ready
  );
  modport sink (
    input valid, input byte_role, input tag_value, input is_constructed,
    input nest_depth, input value_length, input value_offset, input header_done,
    input tag_match, input closed_count, input format_error, input nesting_error,
    output ready
  );
endinterface

// ===== rtl/btlv_cfg_if.sv =====
// Configuration write channel of the BER-TLV stream parser.
interface btlv_cfg_if;
  logic                              valid;
  logic                              ready;
  btlv_pkg::cfg_idx_t                index;
  logic [btlv_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ber_tlv_stream_parser_core.sv =====
// Top level of the BER-TLV stream parser: byte classification and nesting tracker.
//
// Usage: bytes of a BER-TLV stream enter on in_bus, one word each, with frame_last
// marking the final byte of a buffer. For every byte one result word leaves on
// out_bus with its role (padding, tag, length, value), the current tag and length,
// nesting depth, header completion, search match, closed element count and flags.
// Registers search_tag (index 0) and search_nested (index 1) are written on cfg_bus,
// which is always ready; write them only while the parser is idle.
// Flow: a byte accepted from in_bus lands in the input register, is classified
// into the output register, and its result is offered from then on. Throughput
// is one byte per cycle while out_bus takes results; the limiting path is the
// parallel compare of the new position against all open end positions on the stack.
// When out_bus stalls the result holds and in_bus keeps accepting until the input
// register is also full, then in_bus.ready drops until out_bus moves again.
// A synchronous active-low reset empties both registers, clears the parser state and
// sets search_tag to zero and search_nested to one. After a frame_last byte the
// parser state returns to its reset values while the search registers are kept.
module ber_tlv_stream_parser_core #(
  parameter int MAX_DEPTH = btlv_pkg::DEF_MAX_DEPTH,
  parameter int POS_WIDTH = btlv_pkg::DEF_POS_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  btlv_in_if.sink    in_bus,
  btlv_out_if.source out_bus,
  btlv_cfg_if.sink   cfg_bus
);

  localparam int SPW  = $clog2(MAX_DEPTH + 1);
  localparam int IDXW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LW   = (POS_WIDTH > btlv_pkg::LEN_W) ? POS_WIDTH : btlv_pkg::LEN_W;
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
  localparam logic [btlv_pkg::LEN_W-1:0] LEN_MAX = {btlv_pkg::LEN_W{1'b1}};

  localparam logic [2:0] PH_TAG  = 3'd0;
  localparam logic [2:0] PH_TAG2 = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_EXT  = 3'd3;
  localparam logic [2:0] PH_VAL  = 3'd4;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Search registers.
  logic [btlv_pkg::TAG_W-1:0] search_tag_r;
  logic                       search_nested_r;

  // Parser state.
  logic [2:0]                 phase_r, phase_nxt;
  logic [btlv_pkg::TAG_W-1:0] tag_r, tag_nxt;
  logic [btlv_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [1:0]                 left_r, left_nxt;
  logic                       cons_r, cons_nxt;
  logic [POS_WIDTH-1:0]       pos_r, pos_nxt;
  logic [btlv_pkg::OFF_W-1:0] vcnt_r, vcnt_nxt;
  logic [SPW-1:0]             sp_r, sp_nxt;
  logic [POS_WIDTH-1:0]       stack_r [MAX_DEPTH];

  // Output register.
  logic              out_valid_r;
  btlv_pkg::result_t res_r, res_nxt;

  logic                 s1_adv;
  logic                 push;
  logic [POS_WIDTH-1:0] push_end;
  logic [IDXW-1:0]      push_idx;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_adv;
  assign cfg_bus.ready = 1'b1;

  always_comb begin
    logic [7:0]           b;
    logic [POS_WIDTH-1:0] pos_next;
    logic [POS_WIDTH-1:0] top_end;
    logic [IDXW-1:0]      top_idx;
    logic [LW-1:0]        limit;
    logic                 hdone;
    logic                 ferr;
    logic                 nerr;
    logic                 match;
    logic                 run;
    logic [SPW-1:0]       closed;
    btlv_pkg::role_t      role;
    logic [btlv_pkg::OFF_W-1:0] voff;

    b         = s1_byte_r;
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    cons_nxt  = cons_r;
    vcnt_nxt  = vcnt_r;
    role      = btlv_pkg::ROLE_PAD;
    voff      = '0;
    hdone     = 1'b0;
    ferr      = 1'b0;
    nerr      = 1'b0;
    match     = 1'b0;
    push      = 1'b0;
    closed    = '0;
    run       = 1'b1;

    case (phase_r)
      PH_TAG2: begin
        role      = btlv_pkg::ROLE_TAG2;
        tag_nxt   = tag_r | {8'h00, b};
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        role = btlv_pkg::ROLE_LEN_HEAD;
        if (b <= btlv_pkg::LEN_SHORT_MAX) begin
          len_nxt = {8'h00, b};
          hdone   = 1'b1;
        end else if (b == btlv_pkg::LEN_LONG1 || b == btlv_pkg::LEN_LONG2) begin
          len_nxt   = '0;
          left_nxt  = b[1:0];
          phase_nxt = PH_EXT;
        end else begin
          ferr    = 1'b1;
          len_nxt = '0;
          hdone   = 1'b1;
        end
      end
      PH_EXT: begin
        role     = btlv_pkg::ROLE_LEN_EXT;
        len_nxt  = {len_r[7:0], b};
        left_nxt = left_r - 2'd1;
        hdone    = (left_nxt == 2'd0);
      end
      PH_VAL: begin
        role     = btlv_pkg::ROLE_VALUE;
        voff     = vcnt_r;
        vcnt_nxt = vcnt_r + 1'b1;
        if (vcnt_nxt >= len_r) begin
          phase_nxt = PH_TAG;
        end
      end
      default: begin
        if (b != 8'h00) begin
          role     = btlv_pkg::ROLE_TAG1;
          cons_nxt = (b & btlv_pkg::CONS_MASK) != 8'h00;
          len_nxt  = '0;
          if ((b & btlv_pkg::TAG_MORE_MASK) == btlv_pkg::TAG_MORE_MASK) begin
            tag_nxt   = {b, 8'h00};
            phase_nxt = PH_TAG2;
          end else begin
            tag_nxt   = {8'h00, b};
            phase_nxt = PH_LEN;
          end
        end
      end
    endcase

    pos_next = pos_r + 1'b1;
    top_idx  = IDXW'(sp_r - 1'b1);
    top_end  = (sp_r != '0) ? stack_r[top_idx] : '0;
    push_idx = IDXW'(sp_r);

    // Room left in the enclosing element, or the top-level cap.
    if (sp_r != '0) begin
      limit = LW'(POS_WIDTH'(top_end - pos_next));
    end else if (cons_nxt) begin
      limit = LW'(POS_MAX);
    end else begin
      limit = LW'(LEN_MAX);
    end

    if (hdone) begin
      match = (tag_nxt == search_tag_r) && (search_nested_r || sp_r == '0);
      if (LW'(len_nxt) > limit) begin
        nerr    = 1'b1;
        len_nxt = limit[btlv_pkg::LEN_W-1:0];
      end
      if (len_nxt == '0) begin
        phase_nxt = PH_TAG;
      end else if (cons_nxt && sp_r < SPW'(MAX_DEPTH)) begin
        push      = 1'b1;
        phase_nxt = PH_TAG;
      end else begin
        if (cons_nxt) begin
          nerr = 1'b1;
        end
        vcnt_nxt  = '0;
        phase_nxt = PH_VAL;
      end
    end
    push_end = pos_next + POS_WIDTH'(len_nxt);

    // A freshly pushed end lies strictly ahead, so only the old stack can close here.
    if (!push) begin
      for (int k = MAX_DEPTH - 1; k >= 0; k--) begin
        if (SPW'(k) < sp_r) begin
          if (run && stack_r[k] == pos_next) begin
            closed = closed + 1'b1;
          end else begin
            run = 1'b0;
          end
        end
      end
    end
    sp_nxt = push ? (sp_r + 1'b1) : (sp_r - closed);

    if (closed != '0 && phase_nxt != PH_TAG) begin
      nerr      = 1'b1;
      phase_nxt = PH_TAG;
    end

    if (s1_last_r && (phase_nxt != PH_TAG || sp_nxt != '0)) begin
      ferr = 1'b1;
    end

    res_nxt.byte_role      = role;
    res_nxt.tag_value      = (role != btlv_pkg::ROLE_PAD) ? tag_nxt : '0;
    res_nxt.is_constructed = (role != btlv_pkg::ROLE_PAD) ? cons_nxt : 1'b0;
    res_nxt.nest_depth     = btlv_pkg::CNT_W'(sp_r);
    res_nxt.value_length   = (role != btlv_pkg::ROLE_PAD) ? len_nxt : '0;
    res_nxt.value_offset   = voff;
    res_nxt.header_done    = hdone;
    res_nxt.tag_match      = match;
    res_nxt.closed_count   = btlv_pkg::CNT_W'(closed);
    res_nxt.format_error   = ferr;
    res_nxt.nesting_error  = nerr;

    pos_nxt = pos_next;
    if (s1_last_r) begin
      phase_nxt = PH_TAG;
      tag_nxt   = '0;
      len_nxt   = '0;
      left_nxt  = '0;
      cons_nxt  = 1'b0;
      pos_nxt   = '0;
      vcnt_nxt  = '0;
      sp_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_byte_r <= in_bus.data_byte;
      s1_last_r <= in_bus.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_tag_r    <= '0;
      search_nested_r <= 1'b1;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.index)
        btlv_pkg::REG_SEARCH_TAG:    search_tag_r    <= cfg_bus.data;
        btlv_pkg::REG_SEARCH_NESTED: search_nested_r <= cfg_bus.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      tag_r   <= '0;
      len_r   <= '0;
      left_r  <= '0;
      cons_r  <= 1'b0;
      pos_r   <= '0;
      vcnt_r  <= '0;
      sp_r    <= '0;
    end else if (s1_adv) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      cons_r  <= cons_nxt;
      pos_r   <= pos_nxt;
      vcnt_r  <= vcnt_nxt;
      sp_r    <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && push) begin
      stack_r[push_idx] <= push_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.byte_role      = res_r.byte_role;
  assign out_bus.tag_value      = res_r.tag_value;
  assign out_bus.is_constructed = res_r.is_constructed;
  assign out_bus.nest_depth     = res_r.nest_depth;
  assign out_bus.value_length   = res_r.value_length;
  assign out_bus.value_offset   = res_r.value_offset;
  assign out_bus.header_done    = res_r.header_done;
  assign out_bus.tag_match      = res_r.tag_match;
  assign out_bus.closed_count   = res_r.closed_count;
  assign out_bus.format_error   = res_r.format_error;
  assign out_bus.nesting_error  = res_r.nesting_error;

  // The stack never holds more open elements than it has entries.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(MAX_DEPTH))
    else $error("stack pointer beyond stack depth");

  // A match is only reported on the byte that completes a header.
  a_match_on_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.tag_match |-> res_r.header_done)
    else $error("tag match without completed header");

  // Elements closed by a byte must have been open around it.
  a_closed_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (MAX_DEPTH < 16) && out_valid_r && res_r.closed_count != '0
      |-> res_r.closed_count <= res_r.nest_depth)
    else $error("more elements closed than were open");

  // A value offset only appears on value bytes.
  a_offset_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.value_offset != '0 |-> res_r.byte_role == btlv_pkg::ROLE_VALUE)
    else $error("value offset on a non-value byte");

  // The parser is back in its reset state after the last byte of a frame.
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> (sp_r == '0 && phase_r == PH_TAG && pos_r == '0))
    else $error("parser state not cleared after frame end");

endmodule
